FILE: rtl/epff_pkg.sv
// Package for the exterior perimeter flood fill unit.
// Types, constants and the controller state enum. No dependencies.
package epff_pkg;
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;
    localparam int DIM_W        = 9;
    localparam int SUM_W        = 19;

    localparam logic [1:0] C_EMPTY   = 2'd0;
    localparam logic [1:0] C_SOLID   = 2'd1;
    localparam logic [1:0] C_OUTSIDE = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [3:0] {
        ST_LOAD,      // taking cells
        ST_BSCAN,     // walk border cells: read
        ST_BCHK,      // border cell data back, push if empty
        ST_POP,       // pop stack top: read stack
        ST_PADR,      // stack data back, get row/col
        ST_NRD,       // read neighbor z
        ST_NCHK,      // neighbor data back, push if empty
        ST_CRD,       // count: read cell
        ST_CCHK,      // cell data back
        ST_CNRD,      // read neighbor z for count
        ST_CNCHK,     // neighbor data back
        ST_OUT        // hold result
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;     // write incoming cell at load index
        logic load_clr;    // load index back to zero
        logic grid_rd_cur; // read grid at scan position
        logic grid_rd_nb;  // read grid at neighbor z
        logic push_cur;    // mark scan cell outside and push
        logic push_nb;     // mark neighbor outside and push
        logic stk_rd;      // pop: read stack at sp-1
        logic latch_pop;   // take popped index into row/col
        logic scan_clr;    // scan position to origin
        logic scan_adv;    // advance scan position
        logic cnt_sel;     // neighbors taken around the scan position
        logic z_clr;
        logic z_adv;
        logic sum_clr;
        logic sum_inc;
        logic out_set;
        logic out_clr;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       load_last;  // this cell completes the grid
        logic       scan_last;  // scan position is last cell
        logic       scan_border;
        logic       stk_empty;
        logic [1:0] rd_data;    // registered grid read
        logic       nb_valid;   // neighbor z inside grid
        logic       z_last;
    } t_sts;
endpackage

FILE: rtl/epff_datapath.sv
// Datapath: grid memory, fill stack, scan and neighbor counters, sum.
// Depends on epff_pkg.
module epff_datapath
    import epff_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DIM_W-1:0] i_rows,
    input  logic [DIM_W-1:0] i_cols,
    input  logic             i_cell,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    output logic [SUM_W-1:0] o_perimeter
);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int SPW   = $clog2(DEPTH + 1);
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // clamp dimensions to 1..MAX
    logic [DIM_W+1:0] rows_c, cols_c;
    always_comb begin
        rows_c = {2'b0, i_rows};
        cols_c = {2'b0, i_cols};
        if (i_rows == '0) rows_c = (DIM_W+2)'(1);
        else if ({2'b0, i_rows} > (DIM_W+2)'(MAX_ROWS)) rows_c = (DIM_W+2)'(MAX_ROWS);
        if (i_cols == '0) cols_c = (DIM_W+2)'(1);
        else if ({2'b0, i_cols} > (DIM_W+2)'(MAX_COLS)) cols_c = (DIM_W+2)'(MAX_COLS);
    end
    logic [RW:0] last_r;
    logic [CW:0] last_c;
    assign last_r = (RW+1)'(rows_c - 1'b1);
    assign last_c = (CW+1)'(cols_c - 1'b1);

    // memory address is {row, col} at the maximum column width
    logic [1:0]    r_grid [DEPTH];
    logic [AW-1:0] r_stk  [DEPTH];
    logic [1:0]    r_rd;
    logic [AW-1:0] r_stk_rd;

    logic [RW-1:0] r_ld_r, r_sc_r, r_pr;
    logic [CW-1:0] r_ld_c, r_sc_c, r_pc;
    logic [SPW-1:0] r_sp;
    logic [1:0]    r_z;
    logic [SUM_W-1:0] r_sum, r_out, n_sum;

    // neighbor of (r_pr, r_pc) or (r_sc_r, r_sc_c); order +c, -c, -r, +r
    logic          cnt_mode;
    logic [RW-1:0] br;
    logic [CW-1:0] bc;
    logic [RW:0]   nr;
    logic [CW:0]   nc;
    logic          nvalid;
    assign cnt_mode = i_cmd.cnt_sel;
    always_comb begin
        br = r_pr;
        bc = r_pc;
        if (cnt_mode) begin
            br = r_sc_r;
            bc = r_sc_c;
        end
        nr = {1'b0, br};
        nc = {1'b0, bc};
        nvalid = 1'b1;
        case (r_z)
            2'd0: begin
                nc = {1'b0, bc} + 1'b1;
                nvalid = ({1'b0, bc} != last_c);
            end
            2'd1: begin
                nc = {1'b0, bc} - 1'b1;
                nvalid = (bc != '0);
            end
            2'd2: begin
                nr = {1'b0, br} - 1'b1;
                nvalid = (br != '0);
            end
            default: begin
                nr = {1'b0, br} + 1'b1;
                nvalid = ({1'b0, br} != last_r);
            end
        endcase
    end
    logic [AW-1:0] nb_addr, sc_addr, ld_addr;
    assign nb_addr = {nr[RW-1:0], nc[CW-1:0]};
    assign sc_addr = {r_sc_r, r_sc_c};
    assign ld_addr = {r_ld_r, r_ld_c};

    logic [AW-1:0] rd_addr, wr_addr;
    logic [1:0]    wr_data;
    logic          wr_en;
    always_comb begin
        rd_addr = i_cmd.grid_rd_nb ? nb_addr : sc_addr;
        wr_en   = i_cmd.load_wr | i_cmd.push_cur | i_cmd.push_nb;
        wr_addr = ld_addr;
        wr_data = i_cell ? C_SOLID : C_EMPTY;
        if (i_cmd.push_cur) begin
            wr_addr = sc_addr;
            wr_data = C_OUTSIDE;
        end else if (i_cmd.push_nb) begin
            wr_addr = nb_addr;
            wr_data = C_OUTSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_grid[wr_addr] <= wr_data;
        if (i_cmd.grid_rd_cur | i_cmd.grid_rd_nb) r_rd <= r_grid[rd_addr];
        if (i_cmd.push_cur | i_cmd.push_nb) r_stk[r_sp[AW-1:0]] <= wr_addr;
        if (i_cmd.stk_rd) r_stk_rd <= r_stk[AW'(r_sp - 1'b1)];
    end

    logic ld_col_last, sc_col_last;
    assign ld_col_last = ({1'b0, r_ld_c} == last_c);
    assign sc_col_last = ({1'b0, r_sc_c} == last_c);

    // saturating sum; the result register takes the sum including this cycle's side
    always_comb begin
        n_sum = r_sum;
        if (i_cmd.sum_clr) n_sum = '0;
        else if (i_cmd.sum_inc && r_sum != SUM_MAX) n_sum = r_sum + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_r <= '0; r_ld_c <= '0;
            r_sc_r <= '0; r_sc_c <= '0;
            r_sp <= '0; r_z <= '0;
            r_sum <= '0; r_out <= '0;
        end else begin
            if (i_cmd.load_clr) begin
                r_ld_r <= '0; r_ld_c <= '0;
            end else if (i_cmd.load_wr) begin
                if (ld_col_last) begin
                    r_ld_c <= '0;
                    r_ld_r <= r_ld_r + 1'b1;
                end else begin
                    r_ld_c <= r_ld_c + 1'b1;
                end
            end
            if (i_cmd.scan_clr) begin
                r_sc_r <= '0; r_sc_c <= '0;
            end else if (i_cmd.scan_adv) begin
                if (sc_col_last) begin
                    r_sc_c <= '0;
                    r_sc_r <= r_sc_r + 1'b1;
                end else begin
                    r_sc_c <= r_sc_c + 1'b1;
                end
            end
            if (i_cmd.push_cur | i_cmd.push_nb) r_sp <= r_sp + 1'b1;
            else if (i_cmd.stk_rd) r_sp <= r_sp - 1'b1;
            if (i_cmd.z_clr) r_z <= '0;
            else if (i_cmd.z_adv) r_z <= r_z + 1'b1;
            r_sum <= n_sum;
            if (i_cmd.out_set) r_out <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_pop) begin
            r_pr <= r_stk_rd[AW-1:CW];
            r_pc <= r_stk_rd[CW-1:0];
        end
    end

    assign o_sts.load_last   = ld_col_last && ({1'b0, r_ld_r} == last_r);
    assign o_sts.scan_last   = sc_col_last && ({1'b0, r_sc_r} == last_r);
    assign o_sts.scan_border = (r_sc_r == '0) || (r_sc_c == '0) || sc_col_last
                               || ({1'b0, r_sc_r} == last_r);
    assign o_sts.stk_empty   = (r_sp == '0);
    assign o_sts.rd_data     = r_rd;
    assign o_sts.nb_valid    = nvalid;
    assign o_sts.z_last      = (r_z == 2'd3);
    assign o_perimeter       = r_out;
endmodule

FILE: rtl/epff_ctrl.sv
// Controller state machine: load, border fill, stack drain, count, output.
// Depends on epff_pkg.
module epff_ctrl
    import epff_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    input  logic i_cfg_wr,
    input  t_sts i_sts,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_LOAD;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_out_valid = 1'b0;
        case (r_state)
            ST_LOAD: begin
                o_in_stall = 1'b0;
                if (i_cfg_wr) begin
                    o_cmd.load_clr = 1'b1;
                end else if (i_in_valid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_sts.load_last) begin
                        o_cmd.load_clr = 1'b1;
                        o_cmd.scan_clr = 1'b1;
                        n_state = ST_BSCAN;
                    end
                end
            end
            ST_BSCAN: begin
                if (i_sts.scan_border) begin
                    o_cmd.grid_rd_cur = 1'b1;
                    n_state = ST_BCHK;
                end else if (i_sts.scan_last) begin
                    o_cmd.scan_clr = 1'b1;
                    o_cmd.sum_clr  = 1'b1;
                    n_state = ST_CRD;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                end
            end
            ST_BCHK: begin
                if (i_sts.rd_data == C_EMPTY) begin
                    o_cmd.push_cur = 1'b1;
                    n_state = ST_POP;
                end else if (i_sts.scan_last) begin
                    o_cmd.scan_clr = 1'b1;
                    o_cmd.sum_clr  = 1'b1;
                    n_state = ST_CRD;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state = ST_BSCAN;
                end
            end
            ST_POP: begin
                if (i_sts.stk_empty) begin
                    if (i_sts.scan_last) begin
                        o_cmd.scan_clr = 1'b1;
                        o_cmd.sum_clr  = 1'b1;
                        n_state = ST_CRD;
                    end else begin
                        o_cmd.scan_adv = 1'b1;
                        n_state = ST_BSCAN;
                    end
                end else begin
                    o_cmd.stk_rd = 1'b1;
                    n_state = ST_PADR;
                end
            end
            ST_PADR: begin
                o_cmd.latch_pop = 1'b1;
                o_cmd.z_clr = 1'b1;
                n_state = ST_NRD;
            end
            ST_NRD: begin
                if (i_sts.nb_valid) begin
                    o_cmd.grid_rd_nb = 1'b1;
                    n_state = ST_NCHK;
                end else if (i_sts.z_last) begin
                    n_state = ST_POP;
                end else begin
                    o_cmd.z_adv = 1'b1;
                end
            end
            ST_NCHK: begin
                if (i_sts.rd_data == C_EMPTY) o_cmd.push_nb = 1'b1;
                if (i_sts.z_last) begin
                    n_state = ST_POP;
                end else begin
                    o_cmd.z_adv = 1'b1;
                    n_state = ST_NRD;
                end
            end
            ST_CRD: begin
                o_cmd.grid_rd_cur = 1'b1;
                n_state = ST_CCHK;
            end
            ST_CCHK: begin
                o_cmd.z_clr = 1'b1;
                if (i_sts.rd_data == C_SOLID) begin
                    n_state = ST_CNRD;
                end else if (i_sts.scan_last) begin
                    o_cmd.out_set = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    o_cmd.scan_adv = 1'b1;
                    n_state = ST_CRD;
                end
            end
            ST_CNRD: begin
                // grid edge counts at once, no read needed
                o_cmd.cnt_sel = 1'b1;
                if (i_sts.nb_valid) begin
                    o_cmd.grid_rd_nb = 1'b1;
                    n_state = ST_CNCHK;
                end else begin
                    o_cmd.sum_inc = 1'b1;
                    if (i_sts.z_last) begin
                        if (i_sts.scan_last) begin
                            o_cmd.out_set = 1'b1;
                            n_state = ST_OUT;
                        end else begin
                            o_cmd.scan_adv = 1'b1;
                            n_state = ST_CRD;
                        end
                    end else begin
                        o_cmd.z_adv = 1'b1;
                    end
                end
            end
            ST_CNCHK: begin
                o_cmd.cnt_sel = 1'b1;
                if (i_sts.rd_data == C_OUTSIDE && i_sts.nb_valid) o_cmd.sum_inc = 1'b1;
                if (i_sts.z_last) begin
                    if (i_sts.scan_last) begin
                        o_cmd.out_set = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        o_cmd.scan_adv = 1'b1;
                        n_state = ST_CRD;
                    end
                end else begin
                    o_cmd.z_adv = 1'b1;
                    n_state = ST_CNRD;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    o_cmd.out_clr = 1'b1;
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end
endmodule

FILE: rtl/exterior_perimeter_flood_fill_unit.sv
// Exterior perimeter flood fill unit, top level.
// Depends on epff_pkg, epff_ctrl, epff_datapath.
//
// Usage:
//   Cells arrive on i_cell_req (1 solid, 0 empty) in row-major order, one
//   beat per cycle under i_in_valid / o_in_stall. The grid is i_cfg rows
//   (index 0) by cols (index 1); 0 counts as 1, values above the maximum
//   count as the maximum. A register write drops the cells loaded so far.
//   After the last cell the block walks the grid for border cells and
//   floods outside cells through a stack in its own memory: each empty
//   border cell is marked and pushed, and each pop reads its in-range
//   neighbors, marking and pushing the empty ones. The count walk reads
//   each cell and, for a solid cell, counts the neighbors that are off the
//   grid or outside. The result is offered the cycle after the count ends.
//   Loading runs at one cell per cycle; o_in_stall is high from the last
//   cell until the result beat on o_perimeter is taken.
//   While i_out_stall is high the result holds on o_perimeter with
//   o_out_valid high. Reset empties the stack, clears counters and sets
//   rows and cols to 256; the grid memory needs no clearing.
module exterior_perimeter_flood_fill_unit
    import epff_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_cell_req,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [SUM_W-1:0] o_perimeter,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [DIM_W-1:0] i_cfg_data
);
    logic [DIM_W-1:0] r_rows, r_cols;
    logic cfg_wr;
    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= DIM_W'(256);
            r_cols <= DIM_W'(256);
        end else if (cfg_wr) begin
            if (i_cfg_index == CFG_ROWS) r_rows <= i_cfg_data;
            if (i_cfg_index == CFG_COLS) r_cols <= i_cfg_data;
        end
    end

    epff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_wr    (cfg_wr),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    epff_datapath #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rows      (r_rows),
        .i_cols      (r_cols),
        .i_cell      (i_cell_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_perimeter (o_perimeter)
    );
endmodule

FILE: rtl/epff_checker.sv
// Port-level checks for the exterior perimeter flood fill unit.
// Depends on epff_pkg; bound to the top level below.
module epff_checker
    import epff_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [SUM_W-1:0] o_perimeter
);
    // no cell is taken while a result waits
    a_no_in_with_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("input open with result pending");
    // held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_perimeter))
        else $error("result changed under stall");
    // after a result beat the block is back to loading
    a_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall |=> !o_in_stall && !o_out_valid)
        else $error("not back to load after result");
endmodule

bind exterior_perimeter_flood_fill_unit epff_checker u_epff_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_perimeter (o_perimeter)
);

FILE: dv/exterior_perimeter_flood_fill_unit_tb.sv
// Testbench for exterior_perimeter_flood_fill_unit: loads grids, predicts the exterior
// perimeter with a flood fill of its own, checks every result beat.
// Depends on epff_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module exterior_perimeter_flood_fill_unit_tb;
    import epff_pkg::*;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 20;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic             i_cell_req = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [SUM_W-1:0] o_perimeter;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic             i_cfg_index = CFG_ROWS;
    logic [DIM_W-1:0] i_cfg_data = '0;

    exterior_perimeter_flood_fill_unit DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // directed grids; exp < 0 means the predictor supplies the value
    typedef struct {
        int          rw;
        int          cw;
        int          n;
        logic [63:0] bits;
        int          exp;
    } t_grid_row;

    t_grid_row grid_rows[7] = '{
        '{1, 1, 1, 64'h1, 4},           // single solid cell
        '{1, 1, 1, 64'h0, 0},           // single empty cell
        '{3, 3, 9, 64'h1EF, 12},        // ring, enclosed hole adds nothing
        '{2, 2, 4, 64'hF, 8},
        '{2, 3, 3, 64'h5, -1},          // dropped by a write mid-grid
        '{2, 3, 6, 64'h2D, -1},
        '{0, 511, 0, 64'h0, -1}         // clamp only, no cells
    };

    int          snd_idle = 11;
    int          rcv_idle = 82;
    bit          hold_on = 1'b0;
    int          hold_cnt = 0;
    int          fixed_exp = -1;
    int          errors = 0;
    int          grids_done = 0;
    int          cells_done = 0;
    logic [8:0]  m_rows = 9'd256;
    logic [8:0]  m_cols = 9'd256;
    bit          loaded_cells[$];
    logic [SUM_W-1:0] perimeter_q[$];

    function automatic int dim_eff(logic [8:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    function automatic logic [SUM_W-1:0] exterior_sides(bit cells[$], int nr, int nc);
        logic [1:0] g[$];
        int         stk[$];
        int         dr[4] = '{0, 0, -1, 1};
        int         dc[4] = '{1, -1, 0, 0};
        int         idx, r, c, rr, cc, nb;
        int         sum = 0;
        foreach (cells[i]) g.push_back(cells[i] ? C_SOLID : C_EMPTY);
        for (r = 0; r < nr; r++)
            for (c = 0; c < nc; c++)
                if ((r == 0 || c == 0 || r == nr - 1 || c == nc - 1)
                        && g[r * nc + c] == C_EMPTY) begin
                    g[r * nc + c] = C_OUTSIDE;
                    stk.push_back(r * nc + c);
                end
        while (stk.size() > 0) begin
            idx = stk.pop_back();
            r = idx / nc;
            c = idx % nc;
            for (int z = 0; z < 4; z++) begin
                rr = r + dr[z];
                cc = c + dc[z];
                if (rr >= 0 && rr < nr && cc >= 0 && cc < nc) begin
                    nb = rr * nc + cc;
                    if (g[nb] == C_EMPTY) begin
                        g[nb] = C_OUTSIDE;
                        stk.push_back(nb);
                    end
                end
            end
        end
        for (r = 0; r < nr; r++)
            for (c = 0; c < nc; c++) begin
                if (g[r * nc + c] != C_SOLID) continue;
                for (int z = 0; z < 4; z++) begin
                    rr = r + dr[z];
                    cc = c + dc[z];
                    if ((rr < 0 || rr >= nr || cc < 0 || cc >= nc
                            || g[rr * nc + cc] == C_OUTSIDE) && sum < 524287)
                        sum++;
                end
            end
        return sum[SUM_W-1:0];
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // receiver: random stall, or one long hold-off while the sender keeps going
    always @(posedge i_clk) begin
        if (hold_on && hold_cnt < HOLD_CYCLES) begin
            i_out_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rcv_idle);
        end
    end

    // monitor: track config and cells, predict on the last cell, check results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_ROWS) m_rows = i_cfg_data;
                else m_cols = i_cfg_data;
                loaded_cells.delete();
            end
            if (i_in_valid && !o_in_stall) begin
                loaded_cells.push_back(i_cell_req);
                cells_done++;
                if (loaded_cells.size() >= dim_eff(m_rows) * dim_eff(m_cols)) begin
                    if (fixed_exp >= 0)
                        perimeter_q.push_back(fixed_exp[SUM_W-1:0]);
                    else
                        perimeter_q.push_back(exterior_sides(loaded_cells,
                            dim_eff(m_rows), dim_eff(m_cols)));
                    loaded_cells.delete();
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (perimeter_q.size() == 0) begin
                    flag_error($sformatf("unexpected result beat %0d", o_perimeter));
                end else begin
                    if (o_perimeter !== perimeter_q[0])
                        flag_error($sformatf("perimeter %0d, expected %0d",
                            o_perimeter, perimeter_q[0]));
                    void'(perimeter_q.pop_front());
                end
                grids_done++;
            end
        end
    end

    task automatic send_cell(bit v);
        bit st;
        while ($urandom_range(99) < snd_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cell_req <= v;
        do begin
            @(negedge i_clk);
            st = o_in_stall;
            @(posedge i_clk);
        end while (st);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(logic idx, int val);
        bit rdy;
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        wait (perimeter_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[DIM_W-1:0];
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_dims(int rw, int cw);
        write_reg(CFG_ROWS, rw);
        write_reg(CFG_COLS, cw);
    endtask

    // random grid; a few are cut short by the next register write
    task automatic random_grid(int rw, int cw);
        int total, n, density;
        set_dims(rw, cw);
        total = dim_eff(rw[8:0]) * dim_eff(cw[8:0]);
        n = total;
        if (total > 1 && $urandom_range(99) < 5) n = $urandom_range(total - 1);
        density = $urandom_range(100);
        for (int i = 0; i < n; i++) send_cell($urandom_range(99) < density);
    endtask

    function automatic int rand_dim();
        if ($urandom_range(99) < 5) return 0;
        return $urandom_range(1, 8);
    endfunction

    initial begin
        int start_cells;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (grid_rows[k]) begin
            set_dims(grid_rows[k].rw, grid_rows[k].cw);
            fixed_exp = grid_rows[k].exp;
            for (int i = 0; i < grid_rows[k].n; i++) send_cell(grid_rows[k].bits[i]);
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            wait (perimeter_q.size() == 0);
            fixed_exp = -1;
        end

        for (int mode = 0; mode < 3; mode++) begin
            snd_idle = (mode == 0) ? 11 : (mode == 1) ? 82 : 0;
            rcv_idle = (mode == 0) ? 82 : (mode == 1) ? 11 : 0;
            if (mode == 0) begin
                // long receiver hold-off: the second grid backs up into the input
                set_dims(2, 3);
                hold_on = 1'b1;
                for (int i = 0; i < 18; i++) send_cell($urandom_range(1));
            end
            if (mode == 2) begin
                random_grid(0, 511);
                random_grid(300, 1);
                random_grid(256, 256 - 255);
            end
            start_cells = cells_done;
            while (cells_done - start_cells < 330)
                random_grid(rand_dim(), rand_dim());
            // sender waits for the pipeline to drain before the next setting
            i_in_valid <= 1'b0;
            @(negedge i_clk);
            wait (perimeter_q.size() == 0);
        end

        i_in_valid <= 1'b0;
        @(negedge i_clk);
        wait (perimeter_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        $display("Covered %0d cell beats and %0d perimeter results over small,",
                 cells_done, grids_done);
        $display("single-row, single-column and clamped grid sizes.");
        if (errors == 0)
            $display("exterior_perimeter_flood_fill_unit: match");
        else
            $display("exterior_perimeter_flood_fill_unit: mismatch");
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout: run did not finish");
        $display("exterior_perimeter_flood_fill_unit: mismatch");
        $finish;
    end
endmodule

FILE: exterior_perimeter_flood_fill_unit.f
rtl/epff_pkg.sv
rtl/epff_datapath.sv
rtl/epff_ctrl.sv
rtl/exterior_perimeter_flood_fill_unit.sv
rtl/epff_checker.sv
dv/exterior_perimeter_flood_fill_unit_tb.sv
